FILE: hw/rtl/edma_pkg.sv
// ----------------------------------------------------------------------------
// edma_pkg
// Shared types, constants and the microcode table of the echo distance filter.
// ----------------------------------------------------------------------------
package edma_pkg;

	localparam int WINDOW   = 5;
	localparam int TICKS_W  = 16;
	localparam int DIST_W   = 10;
	localparam int SAMP_W   = 3;
	localparam int DIV_W    = 16;
	localparam int ITER_W   = $clog2(DIV_W);
	localparam int POS_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int SUM_W    = $clog2(WINDOW * ((1 << DIST_W) - 1) + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STEP_W   = 3;

	localparam logic [TICKS_W-1:0] TICKS_PER_CM_RST = TICKS_W'(117);
	localparam logic [DIST_W-1:0]  MAX_RANGE_CM_RST = DIST_W'(400);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE_CM = CFG_IDX_W'(1);

	// datapath operations
	localparam logic [2:0] OP_NOP       = 3'd0;
	localparam logic [2:0] OP_LOAD_ECHO = 3'd1;
	localparam logic [2:0] OP_DIV_STEP  = 3'd2;
	localparam logic [2:0] OP_RANGE     = 3'd3;
	localparam logic [2:0] OP_ACC       = 3'd4;
	localparam logic [2:0] OP_LOAD_AVG  = 3'd5;
	localparam logic [2:0] OP_EMIT      = 3'd6;

	// hold conditions: the step repeats while its condition is true
	localparam logic [2:0] COND_NEVER    = 3'd0;
	localparam logic [2:0] COND_NO_IN    = 3'd1;
	localparam logic [2:0] COND_DIV_MORE = 3'd2;
	localparam logic [2:0] COND_ACC_MORE = 3'd3;
	localparam logic [2:0] COND_OUT_BUSY = 3'd4;

	// program steps
	localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_DIV1  = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_RANGE = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_ACC   = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_LOAD  = STEP_W'(4);
	localparam logic [STEP_W-1:0] STEP_DIV2  = STEP_W'(5);
	localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(6);

	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        hold;
		logic [STEP_W-1:0] next;
	} ucode_t;

	typedef struct packed {
		logic [2:0] op;
	} dp_ctrl_t;

	typedef struct packed {
		logic no_in;
		logic div_last;
		logic acc_last;
		logic out_blocked;
	} dp_stat_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks_per_cm;
		logic [DIST_W-1:0]  max_range_cm;
	} cfg_t;

	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t uc;
		case (step)
			STEP_WAIT:  uc = '{op: OP_LOAD_ECHO, hold: COND_NO_IN,    next: STEP_DIV1};
			STEP_DIV1:  uc = '{op: OP_DIV_STEP,  hold: COND_DIV_MORE, next: STEP_RANGE};
			STEP_RANGE: uc = '{op: OP_RANGE,     hold: COND_NEVER,    next: STEP_ACC};
			STEP_ACC:   uc = '{op: OP_ACC,       hold: COND_ACC_MORE, next: STEP_LOAD};
			STEP_LOAD:  uc = '{op: OP_LOAD_AVG,  hold: COND_NEVER,    next: STEP_DIV2};
			STEP_DIV2:  uc = '{op: OP_DIV_STEP,  hold: COND_DIV_MORE, next: STEP_EMIT};
			STEP_EMIT:  uc = '{op: OP_EMIT,      hold: COND_OUT_BUSY, next: STEP_WAIT};
			default:    uc = '{op: OP_NOP,       hold: COND_NEVER,    next: STEP_WAIT};
		endcase
		return uc;
	endfunction

endpackage

FILE: hw/rtl/edma_seq.sv
// ----------------------------------------------------------------------------
// edma_seq
// Step counter and microcode table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module edma_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  edma_pkg::dp_stat_t stat,
	output edma_pkg::dp_ctrl_t ctrl
);
	import edma_pkg::*;

	logic [STEP_W-1:0] step_q;
	ucode_t            uc;
	logic              hold;

	assign uc = ucode_rom(step_q);
	assign ctrl.op = uc.op;

	always_comb begin
		case (uc.hold)
			COND_NEVER:    hold = 1'b0;
			COND_NO_IN:    hold = stat.no_in;
			COND_DIV_MORE: hold = !stat.div_last;
			COND_ACC_MORE: hold = !stat.acc_last;
			COND_OUT_BUSY: hold = stat.out_blocked;
			default:       hold = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (!hold) begin
			step_q <= uc.next;
		end
	end

	// an accepted beat always starts the first division
	a_accept_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(uc.op == OP_LOAD_ECHO && !stat.no_in) |=> step_q == STEP_DIV1)
		else $error("accepted beat did not start division");

endmodule

FILE: hw/rtl/edma_dp.sv
// ----------------------------------------------------------------------------
// edma_dp
// Datapath: shared restoring divider, distance ring, accumulator, output stage.
// ----------------------------------------------------------------------------
module edma_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  edma_pkg::dp_ctrl_t          ctrl,
	output edma_pkg::dp_stat_t          stat,
	input  edma_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [edma_pkg::TICKS_W-1:0] echo_ticks,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [edma_pkg::DIST_W-1:0] average_cm,
	output logic [edma_pkg::DIST_W-1:0] raw_cm,
	output logic [edma_pkg::SAMP_W-1:0] samples_used
);
	import edma_pkg::*;

	// divider
	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;
	logic [DIV_W:0]    rs;
	logic [DIV_W+1:0]  diff;
	logic              ge;

	// ring and averaging
	logic [DIST_W-1:0] ring_q [WINDOW];
	logic [POS_W-1:0]  pos_q;
	logic              full_q;
	logic [POS_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count;
	logic [DIST_W-1:0] raw_q;
	logic [DIST_W-1:0] raw_next;

	// output stage
	logic              out_valid_q;
	logic [DIST_W-1:0] avg_out_q;
	logic [DIST_W-1:0] raw_out_q;
	logic [SAMP_W-1:0] samp_out_q;
	logic              out_blocked;
	logic              in_beat;

	assign in_ready    = (ctrl.op == OP_LOAD_ECHO);
	assign in_beat     = in_valid && in_ready;
	assign out_blocked = out_valid_q && !out_ready;

	assign rs   = {rem_q, dvd_q[DIV_W-1]};
	assign diff = {1'b0, rs} - {2'b00, dvs_q};
	assign ge   = !diff[DIV_W+1];

	assign count = full_q ? CNT_W'(WINDOW) : CNT_W'(pos_q);

	// zero divisor or out-of-range quotient gives no distance
	assign raw_next = (cfg.ticks_per_cm == '0 || dvd_q > DIV_W'(cfg.max_range_cm)) ?
		'0 : dvd_q[DIST_W-1:0];

	assign stat.no_in       = !in_valid;
	assign stat.div_last    = (iter_q == ITER_W'(DIV_W - 1));
	assign stat.acc_last    = (CNT_W'(idx_q) == count - CNT_W'(1));
	assign stat.out_blocked = out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			full_q      <= 1'b0;
			iter_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new beat may replace one taken at the same edge
			if (ctrl.op == OP_EMIT && !out_blocked)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (ctrl.op)
				OP_LOAD_ECHO: begin
					iter_q <= '0;
				end
				OP_DIV_STEP: begin
					iter_q <= iter_q + ITER_W'(1);
				end
				OP_RANGE: begin
					idx_q <= '0;
					if (pos_q == POS_W'(WINDOW - 1)) begin
						pos_q  <= '0;
						full_q <= 1'b1;
					end else begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
				OP_ACC: begin
					idx_q <= idx_q + POS_W'(1);
				end
				OP_LOAD_AVG: begin
					iter_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD_ECHO: begin
				if (in_beat) begin
					dvd_q <= echo_ticks;
					dvs_q <= cfg.ticks_per_cm;
					rem_q <= '0;
				end
			end
			OP_DIV_STEP: begin
				rem_q <= ge ? diff[DIV_W-1:0] : rs[DIV_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], ge};
			end
			OP_RANGE: begin
				ring_q[pos_q] <= raw_next;
				raw_q         <= raw_next;
				sum_q         <= '0;
			end
			OP_ACC: begin
				sum_q <= sum_q + SUM_W'(ring_q[idx_q]);
			end
			OP_LOAD_AVG: begin
				dvd_q <= DIV_W'(sum_q);
				dvs_q <= DIV_W'(count);
				rem_q <= '0;
			end
			OP_EMIT: begin
				if (!out_blocked) begin
					avg_out_q  <= dvd_q[DIST_W-1:0];
					raw_out_q  <= raw_q;
					samp_out_q <= SAMP_W'(count);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign average_cm   = avg_out_q;
	assign raw_cm       = raw_out_q;
	assign samples_used = samp_out_q;

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_ACC) |-> count != '0)
		else $error("averaging over an empty window");

	// a mean never exceeds its largest entry, so the quotient fits the field
	a_avg_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == OP_EMIT && !out_blocked) |-> dvd_q[DIV_W-1:DIST_W] == '0)
		else $error("average quotient wider than field");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.op) == OP_EMIT)
		else $error("result raised outside emit step");

endmodule

FILE: hw/rtl/echo_distance_moving_average.sv
// ----------------------------------------------------------------------------
// echo_distance_moving_average
// Echo pulse length to distance in cm, averaged over a ring of recent samples.
//
//   port group      dir  handshake           payload
//   in              in   in_valid/in_ready   echo_ticks
//   out             out  out_valid/out_ready average_cm, raw_cm, samples_used
//   cfg             in   cfg_we              cfg_index, cfg_data
//
// One item at a time: each result takes two 16-step passes of the shared
// bit-serial divider, and the average is taken over 1..5 entries.
// The next beat is taken as soon as the result sits in the output register.
// Reset clears the step counter, ring position and warm-up flag; config
// registers return to 117 ticks/cm and 400 cm. A stalled output holds the
// sequencer at its emit step.
// ----------------------------------------------------------------------------
module echo_distance_moving_average (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [edma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [edma_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [edma_pkg::TICKS_W-1:0]   echo_ticks,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [edma_pkg::DIST_W-1:0]    average_cm,
	output logic [edma_pkg::DIST_W-1:0]    raw_cm,
	output logic [edma_pkg::SAMP_W-1:0]    samples_used
);
	import edma_pkg::*;

	cfg_t     cfg_q;
	dp_ctrl_t ctrl;
	dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_cm <= TICKS_PER_CM_RST;
			cfg_q.max_range_cm <= MAX_RANGE_CM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_CM: cfg_q.ticks_per_cm <= cfg_data[TICKS_W-1:0];
				REG_MAX_RANGE_CM: cfg_q.max_range_cm <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	edma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	edma_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.echo_ticks   (echo_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.average_cm   (average_cm),
		.raw_cm       (raw_cm),
		.samples_used (samples_used)
	);

endmodule
